FILE: rtl/ncl_pkg.sv
// Shared types and constants for the online nearest-centroid learner.
// No dependencies; ncl_div and the top level import this package, ncl_ram does not.
package ncl_pkg;

  localparam int VecLen    = 64;
  localparam int VecAw     = 6;
  localparam int IssW      = VecAw + 1;
  localparam int MaxStored = 256;
  localparam int SlotAw    = 8;
  localparam int CntW      = SlotAw + 1;
  localparam int CentDepth = VecLen * MaxStored;
  localparam int CentAw    = VecAw + SlotAw;
  localparam int FeatW     = 15;
  localparam int KindW     = 3;
  localparam int SupW      = 32;
  localparam int ConfW     = 10;
  localparam int ScoreW    = 10;
  localparam int SqW       = 2 * (FeatW);
  localparam int SumW      = 36;
  localparam int RootW     = SumW / 2;
  localparam int RemW      = RootW + 3;
  localparam int SqcW      = 5;
  localparam int ProdW     = 16 + ScoreW;
  localparam int AccW      = 48;
  localparam int DivW      = AccW - 1;
  localparam int DvsW      = SupW + 1;
  localparam int DivCntW   = 6;

  localparam logic [ScoreW-1:0] ScoreMax = 10'd1000;
  localparam logic [ConfW-1:0]  ConfNew  = 10'd500;
  localparam logic [ConfW-1:0]  ConfStep = 10'd10;
  localparam logic [ConfW-1:0]  ConfMax  = 10'd1000;
  localparam logic [ScoreW-1:0] ThrReset = 10'd800;

  typedef enum logic [1:0] {
    ST_MATCH = 2'd0,
    ST_NEW   = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [FeatW-1:0] feature_value;
    logic [KindW-1:0]        pattern_kind;
    logic                    last_element;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        result_status;
    logic [CntW-1:0]   pattern_number;
    logic [ScoreW-1:0] match_score;
    logic [ConfW-1:0]  pattern_confidence;
    logic [SupW-1:0]   pattern_support;
  } out_item_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [SupW-1:0]  support;
    logic [ConfW-1:0] conf;
  } meta_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_META,
    S_STREAM,
    S_SQRT,
    S_SCORE,
    S_CMP,
    S_DECIDE,
    S_MRD,
    S_MMUL,
    S_MSTART,
    S_MWAIT,
    S_MFIN,
    S_COPY,
    S_OUT
  } state_e;

endpackage

FILE: rtl/ncl_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ncl_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/ncl_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on ncl_pkg for operand widths.
module ncl_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ncl_pkg::DivW-1:0]   dividend_i,
  input  logic [ncl_pkg::DvsW-1:0]   divisor_i,
  output logic                       done_o,
  output logic [ncl_pkg::DivW-1:0]   quot_o
);
  import ncl_pkg::*;

  logic               busy_q, done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DvsW:0]      rem_q;
  logic [DivW-1:0]    quo_q;
  logic [DvsW-1:0]    dvs_q;
  logic [DvsW:0]      rem_sh;
  logic [DvsW:0]      rem_sub;
  logic               take;

  // trial subtraction for the current bit
  always_comb begin
    rem_sh  = {rem_q[DvsW-1:0], quo_q[DivW-1]};
    take    = (rem_sh >= {1'b0, dvs_q});
    rem_sub = rem_sh - {1'b0, dvs_q};
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= take ? rem_sub : rem_sh;
      quo_q <= {quo_q[DivW-2:0], take};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

FILE: rtl/online_nearest_centroid_learner.sv
// Online nearest-centroid learner: top level with sequencer and memories.
// Depends on ncl_pkg, ncl_ram and ncl_div.
// A non-last element is stored in the vector buffer. For a last element the scan
// streams each stored pattern of its kind (stream, 18-step root, score, compare) and
// skips other patterns; then the vector is copied (new pattern), one division per
// element is run (match) or neither is done (store full), then the output register loads.
// One vector is in flight at a time; the output register holds the result under stall.
// Reset (async, active low) clears the pattern count, index and threshold (800).
module online_nearest_centroid_learner (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  ncl_pkg::in_item_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output ncl_pkg::out_item_t          out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ncl_pkg::ScoreW-1:0]  cfg_data_i
);
  import ncl_pkg::*;

  state_e state_q, state_d;

  logic [ScoreW-1:0] thr_q;
  logic [VecAw-1:0]  idx_q, last_pos_q, idx1_q;
  logic [KindW-1:0]  kind_q;
  logic [CntW-1:0]   cnt_q, slot_q;
  logic [SlotAw-1:0] slot_m1, win_q;
  logic [ScoreW-1:0] best_q;
  logic              found_q;
  meta_t             cur_meta_q, win_meta_q;
  logic [IssW-1:0]   iss_q;
  logic              rv1_q, v2_q, v3_q;
  logic [FeatW-1:0]  diff_q;
  logic [SqW-1:0]    sq_q;
  logic [SumW-1:0]   sum_q;
  logic [RootW-1:0]  root_q;
  logic [RemW-1:0]   rem_q;
  logic [SqcW-1:0]   sqc_q;
  logic [ProdW-1:0]  prod_q;
  logic              big_q;
  logic signed [AccW-1:0] acc_q;
  out_item_t         res_q, out_q;
  logic              out_valid_q;

  logic in_acc, issue, out_load;

  // memory ports
  logic [FeatW-1:0]  vbuf_rd, cent_rd, cent_wdata;
  logic [CentAw-1:0] cent_raddr, cent_waddr;
  logic              cent_we, meta_we;
  logic [SlotAw-1:0] meta_waddr;
  meta_t             meta_rd, meta_wdata;

  // divider
  logic               div_start, div_done;
  logic [DivW-1:0]    div_mag, div_q;
  logic [DvsW-1:0]    div_dvs;

  // element arithmetic
  logic signed [FeatW-1:0] vmask;
  logic signed [15:0]      d16, a16;
  logic signed [AccW-1:0]  mul_w;
  logic [FeatW-1:0]        qmag;
  logic [RemW-1:0]         rem_sh, trial;
  logic [ScoreW-1:0]       score_w;
  logic [SupW-1:0]         sup_n;
  logic [ConfW:0]          conf_sum;
  logic [ConfW-1:0]        conf_n;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign slot_m1     = SlotAw'(slot_q - 1'b1);
  assign out_load    = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  // element values past the last one count as zero
  assign vmask = (idx1_q <= last_pos_q) ? $signed(vbuf_rd) : '0;
  assign d16   = 16'($signed(cent_rd)) - 16'(vmask);
  assign a16   = d16[15] ? -d16 : d16;
  assign mul_w = $signed(cent_rd) * $signed({1'b0, win_meta_q.support});

  // square-root step
  assign rem_sh = {rem_q[RemW-3:0], sum_q[SumW-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};

  // score from the root: 1000 - floor(D*1000/65536), zero when out of range
  assign score_w = big_q ? '0 : ScoreMax - prod_q[ProdW-1 -: ScoreW];

  // running mean
  assign div_mag = acc_q[AccW-1] ? DivW'(-acc_q) : DivW'(acc_q);
  assign div_dvs = {1'b0, win_meta_q.support} + 1'b1;
  assign qmag    = div_q[FeatW-1:0];

  // winner update
  assign sup_n    = (&win_meta_q.support) ? win_meta_q.support
                                          : win_meta_q.support + 1'b1;
  assign conf_sum = {1'b0, win_meta_q.conf} + {1'b0, ConfStep};
  assign conf_n   = (conf_sum > {1'b0, ConfMax}) ? ConfMax : conf_sum[ConfW-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_acc && in_data_i.last_element) state_d = S_SCAN;
      S_SCAN:   state_d = (slot_q == '0) ? S_DECIDE : S_META;
      S_META:   state_d = (meta_rd.kind == kind_q) ? S_STREAM : S_SCAN;
      S_STREAM: if (iss_q[VecAw] && !rv1_q && !v2_q && !v3_q) state_d = S_SQRT;
      S_SQRT:   if (sqc_q == SqcW'(RootW - 1)) state_d = S_SCORE;
      S_SCORE:  state_d = S_CMP;
      S_CMP:    state_d = S_SCAN;
      S_DECIDE: begin
        if (found_q) state_d = S_MRD;
        else if (!cnt_q[SlotAw]) state_d = S_COPY;
        else state_d = S_OUT;
      end
      S_MRD:    state_d = S_MMUL;
      S_MMUL:   state_d = S_MSTART;
      S_MSTART: state_d = S_MWAIT;
      S_MWAIT: begin
        if (div_done) state_d = (iss_q == IssW'(VecLen - 1)) ? S_MFIN : S_MRD;
      end
      S_MFIN:   state_d = S_OUT;
      S_COPY:   if (iss_q[VecAw] && !rv1_q) state_d = S_OUT;
      S_OUT:    if (out_load) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // control outputs and memory ports
  always_comb begin
    in_stall_o = (state_q != S_IDLE);
    issue      = 1'b0;
    div_start  = 1'b0;
    cent_we    = 1'b0;
    cent_waddr = {cnt_q[SlotAw-1:0], idx1_q};
    cent_wdata = vmask;
    cent_raddr = {slot_m1, iss_q[VecAw-1:0]};
    meta_we    = 1'b0;
    meta_waddr = cnt_q[SlotAw-1:0];
    meta_wdata = '{kind: kind_q, support: SupW'(1), conf: ConfNew};
    unique case (state_q) inside
      S_STREAM: issue = !iss_q[VecAw];
      S_COPY: begin
        issue   = !iss_q[VecAw];
        cent_we = rv1_q;
        meta_we = iss_q[VecAw] && !rv1_q;
      end
      S_MRD, S_MMUL: cent_raddr = {win_q, iss_q[VecAw-1:0]};
      S_MSTART: div_start = 1'b1;
      S_MWAIT: begin
        cent_we    = div_done;
        cent_waddr = {win_q, iss_q[VecAw-1:0]};
        cent_wdata = acc_q[AccW-1] ? FeatW'(-qmag) : qmag;
      end
      S_MFIN: begin
        meta_we    = 1'b1;
        meta_waddr = win_q;
        meta_wdata = '{kind: win_meta_q.kind, support: sup_n, conf: conf_n};
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      thr_q       <= ThrReset;
      idx_q       <= '0;
      cnt_q       <= '0;
      slot_q      <= '0;
      found_q     <= 1'b0;
      iss_q       <= '0;
      rv1_q       <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      sqc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) thr_q <= cfg_data_i;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (out_load) out_valid_q <= 1'b1;
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (in_data_i.last_element) begin
              idx_q   <= '0;
              slot_q  <= cnt_q;
              found_q <= 1'b0;
            end else if (idx_q != VecAw'(VecLen - 1)) begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        S_META: begin
          iss_q <= '0;
          rv1_q <= 1'b0;
          v2_q  <= 1'b0;
          v3_q  <= 1'b0;
          if (meta_rd.kind != kind_q) slot_q <= slot_q - 1'b1;
        end
        S_STREAM: begin
          if (issue) iss_q <= iss_q + 1'b1;
          rv1_q <= issue;
          v2_q  <= rv1_q;
          v3_q  <= v2_q;
          sqc_q <= '0;
        end
        S_SQRT: sqc_q <= sqc_q + 1'b1;
        S_CMP: begin
          if (score_w > best_q && score_w >= thr_q) found_q <= 1'b1;
          slot_q <= slot_q - 1'b1;
        end
        S_DECIDE: begin
          iss_q <= '0;
          rv1_q <= 1'b0;
        end
        S_MWAIT: if (div_done) iss_q <= iss_q + 1'b1;
        S_COPY: begin
          if (issue) iss_q <= iss_q + 1'b1;
          rv1_q <= issue;
          if (iss_q[VecAw] && !rv1_q) cnt_q <= cnt_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= res_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && in_data_i.last_element) begin
          last_pos_q <= idx_q;
          kind_q     <= in_data_i.pattern_kind;
          best_q     <= '0;
        end
      end
      S_META: begin
        cur_meta_q <= meta_rd;
        sum_q      <= '0;
      end
      S_STREAM: begin
        idx1_q <= iss_q[VecAw-1:0];
        diff_q <= a16[FeatW-1:0];
        sq_q   <= diff_q * diff_q;
        if (v3_q) sum_q <= sum_q + SumW'(sq_q);
        root_q <= '0;
        rem_q  <= '0;
      end
      S_SQRT: begin
        sum_q <= {sum_q[SumW-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_q  <= rem_sh - trial;
          root_q <= {root_q[RootW-2:0], 1'b1};
        end else begin
          rem_q  <= rem_sh;
          root_q <= {root_q[RootW-2:0], 1'b0};
        end
      end
      S_SCORE: begin
        prod_q <= root_q[15:0] * ScoreMax;
        big_q  <= |root_q[RootW-1:16];
      end
      S_CMP: begin
        if (score_w > best_q && score_w >= thr_q) begin
          best_q     <= score_w;
          win_q      <= slot_m1;
          win_meta_q <= cur_meta_q;
        end
      end
      S_DECIDE: begin
        res_q <= '{result_status: ST_FULL, pattern_number: '0, match_score: '0,
                   pattern_confidence: '0, pattern_support: '0};
      end
      S_MRD:  idx1_q <= iss_q[VecAw-1:0];
      S_MMUL: acc_q  <= mul_w + AccW'(vmask);
      S_MFIN: begin
        res_q <= '{result_status: ST_MATCH, pattern_number: CntW'(win_q) + 1'b1,
                   match_score: best_q, pattern_confidence: conf_n,
                   pattern_support: sup_n};
      end
      S_COPY: begin
        idx1_q <= iss_q[VecAw-1:0];
        if (iss_q[VecAw] && !rv1_q) begin
          res_q <= '{result_status: ST_NEW, pattern_number: cnt_q + 1'b1,
                     match_score: best_q, pattern_confidence: ConfNew,
                     pattern_support: SupW'(1)};
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // vector buffer
  ncl_ram #(.Width(FeatW), .Depth(VecLen)) u_vbuf (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (idx_q),
    .wdata_i (in_data_i.feature_value),
    .raddr_i (iss_q[VecAw-1:0]),
    .rdata_o (vbuf_rd)
  );

  // centroid store, one row of elements per pattern
  ncl_ram #(.Width(FeatW), .Depth(CentDepth)) u_cent (
    .clk_i   (clk_i),
    .we_i    (cent_we),
    .waddr_i (cent_waddr),
    .wdata_i (cent_wdata),
    .raddr_i (cent_raddr),
    .rdata_o (cent_rd)
  );

  // per-pattern kind, support and confidence
  ncl_ram #(.Width($bits(meta_t)), .Depth(MaxStored)) u_meta (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .raddr_i (slot_m1),
    .rdata_o (meta_rd)
  );

  ncl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_mag),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

endmodule
